// File: rtl/core/wbps_pkg.sv
`timescale 1ns / 1ps
package wbps_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int BYTE_W      = 8;
    localparam int ADDR_W      = 64;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int POS_W       = $clog2(MAX_PATTERN);
    localparam int APB_DATA_W  = 64;
    localparam int APB_ADDR_W  = 5;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 64;

    // Register index, taken from paddr[4:3] (registers sit 8 bytes apart).
    localparam logic [1:0] REG_PAT_LOW  = 2'd0;
    localparam logic [1:0] REG_PAT_HIGH = 2'd1;
    localparam logic [1:0] REG_WILD     = 2'd2;
    localparam logic [1:0] REG_LEN      = 2'd3;

    typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0] t_window;

    typedef struct packed {
        logic [63:0]            pat_high;
        logic [63:0]            pat_low;
        logic [MAX_PATTERN-1:0] wild_mask;
        logic [LEN_W-1:0]       pat_len;
    } t_cfg;

    typedef struct packed {
        logic             hit;
        logic [LEN_W-1:0] len;
    } t_match;

endpackage

// File: rtl/core/wbps_cfg_regs.sv
`timescale 1ns / 1ps
module wbps_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wbps_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [wbps_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [wbps_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output wbps_pkg::t_cfg                      o_cfg
);
    import wbps_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:3];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pat_low   <= '0;
            r_cfg.pat_high  <= '0;
            r_cfg.wild_mask <= '0;
            r_cfg.pat_len   <= LEN_W'(1);
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PAT_LOW:  r_cfg.pat_low   <= pwdata[63:0];
                REG_PAT_HIGH: r_cfg.pat_high  <= pwdata[63:0];
                REG_WILD:     r_cfg.wild_mask <= pwdata[MAX_PATTERN-1:0];
                REG_LEN:      r_cfg.pat_len   <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_PAT_LOW:  prdata = r_cfg.pat_low;
            REG_PAT_HIGH: prdata = r_cfg.pat_high;
            REG_WILD:     prdata = APB_DATA_W'(r_cfg.wild_mask);
            REG_LEN:      prdata = APB_DATA_W'(r_cfg.pat_len);
            default:      prdata = '0;
        endcase
    end

endmodule

// File: rtl/core/wbps_matcher.sv
`timescale 1ns / 1ps
module wbps_matcher (
    input  wbps_pkg::t_window                   i_window,
    input  logic [wbps_pkg::BYTE_W-1:0]         i_data_byte,
    input  logic [wbps_pkg::LEN_W-1:0]          i_fill,
    input  wbps_pkg::t_cfg                      i_cfg,
    output wbps_pkg::t_match                    o_match
);
    import wbps_pkg::*;

    t_window                new_win;
    t_window                pattern;
    logic [LEN_W-1:0]       eff_len;
    logic [LEN_W-1:0]       fill_next;
    logic [MAX_PATTERN-1:0] pos_ok;

    assign pattern = {i_cfg.pat_high, i_cfg.pat_low};
    assign new_win = {i_window[MAX_PATTERN-2:0], i_data_byte};
    assign eff_len = (i_cfg.pat_len > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                          : i_cfg.pat_len;
    assign fill_next = (i_fill < LEN_W'(MAX_PATTERN)) ? i_fill + LEN_W'(1) : i_fill;

    // Pattern byte i lines up with window slot len-1-i (slot 0 is the newest byte).
    always_comb begin
        logic [LEN_W-1:0] slot;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            slot = eff_len - LEN_W'(i) - LEN_W'(1);
            pos_ok[i] = (LEN_W'(i) >= eff_len) || i_cfg.wild_mask[i]
                        || (new_win[slot[POS_W-1:0]] == pattern[i]);
        end
    end

    assign o_match.hit = (eff_len != '0) && (fill_next >= eff_len) && (&pos_ok);
    assign o_match.len = eff_len;

endmodule

// File: rtl/core/wildcard_byte_pattern_scanner.sv
`timescale 1ns / 1ps
// Pipeline: an accepted byte waits in the input register; when it fires, its result, if any,
// is loaded into the result register, which drives o_m_axis_tvalid until it is taken.
// Throughput: one byte per cycle unless a held result stalls; window compare is combinational.
// Reset (synchronous, active low) clears the window, fill count and match flag,
// empties both registers and restores pattern_length to 1, all else to zero.
module wildcard_byte_pattern_scanner (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [7:0] data_byte, [71:8] byte_address
    input  logic [wbps_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    input  logic                                i_s_axis_tlast,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [63:0] match_address
    output logic [wbps_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // [0] found
    output logic                                o_m_axis_tuser,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wbps_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [wbps_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [wbps_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import wbps_pkg::*;

    t_cfg   cfg;
    t_match match;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_data;
    logic [ADDR_W-1:0] r_in_addr;
    logic              r_in_last;

    t_window           r_win;
    logic [LEN_W-1:0]  r_fill;
    logic              r_done;

    logic              r_out_valid;
    logic              r_out_found;
    logic [ADDR_W-1:0] r_out_addr;

    logic              out_free;
    logic              fire;
    logic              s_accept;
    logic              emit;

    wbps_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    wbps_matcher u_match (
        .i_window    (r_win),
        .i_data_byte (r_in_data),
        .i_fill      (r_fill),
        .i_cfg       (cfg),
        .o_match     (match)
    );

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign fire            = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || fire;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign emit            = fire && !r_done && (match.hit || r_in_last);

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_addr;
    assign o_m_axis_tuser  = r_out_found;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
        if (s_accept) begin
            r_in_data <= i_s_axis_tdata[BYTE_W-1:0];
            r_in_addr <= i_s_axis_tdata[BYTE_W +: ADDR_W];
            r_in_last <= i_s_axis_tlast;
        end
    end

    // Region state: bytes after a match only wait for the end of the region.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= '0;
            r_fill <= '0;
            r_done <= 1'b0;
        end else if (fire) begin
            if (r_in_last) begin
                r_win  <= '0;
                r_fill <= '0;
                r_done <= 1'b0;
            end else if (!r_done) begin
                r_win <= {r_win[MAX_PATTERN-2:0], r_in_data};
                if (r_fill < LEN_W'(MAX_PATTERN)) begin
                    r_fill <= r_fill + LEN_W'(1);
                end
                r_done <= match.hit;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (emit) begin
            r_out_found <= match.hit;
            r_out_addr  <= match.hit ? r_in_addr - ADDR_W'(match.len - LEN_W'(1))
                                     : '0;
        end
    end

    a_fill_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LEN_W'(MAX_PATTERN))
        else $error("fill count above window depth");

    a_done_has_bytes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_fill != '0))
        else $error("match flag set with an empty window");

    a_miss_zero_addr : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_addr == '0))
        else $error("not-found result carries a nonzero address");

    a_clear_on_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_last) |=> ((r_fill == '0) && !r_done))
        else $error("region state not cleared after the last byte");

endmodule

// File: test/wildcard_byte_pattern_scanner_test.sv
`timescale 1ns / 1ps
module wildcard_byte_pattern_scanner_test;
    import wbps_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int BYTES_PER_STEP = 130;
    localparam int STEP_COUNT     = 11;

    typedef struct {
        logic        found;
        logic [63:0] addr;
    } t_scan_report;

    class scan_scoreboard;
        logic [7:0]   window [MAX_PATTERN];
        int           fill;
        bit           done;
        logic [63:0]  pat_low;
        logic [63:0]  pat_high;
        logic [15:0]  wild;
        logic [4:0]   plen;
        t_scan_report expected_reports[$];
        int           errors;

        function new();
            pat_low  = '0;
            pat_high = '0;
            wild     = '0;
            plen     = 5'd1;
            errors   = 0;
            clear_region();
        endfunction

        function void clear_region();
            foreach (window[k]) window[k] = 8'h00;
            fill = 0;
            done = 1'b0;
        endfunction

        function void set_register(input logic [1:0] idx, input logic [63:0] value);
            case (idx)
                REG_PAT_LOW:  pat_low  = value;
                REG_PAT_HIGH: pat_high = value;
                REG_WILD:     wild     = value[15:0];
                REG_LEN:      plen     = value[4:0];
                default: ;
            endcase
        endfunction

        function int active_length();
            return (plen > MAX_PATTERN) ? MAX_PATTERN : int'(plen);
        endfunction

        function logic [7:0] pattern_at(input int pos);
            logic [127:0] both;
            both = {pat_high, pat_low};
            return both[8*pos +: 8];
        endfunction

        function bit window_hits(input int len);
            for (int i = 0; i < len; i++) begin
                if (!wild[i] && window[len-1-i] != pattern_at(i)) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_byte(input logic [7:0] data, input logic [63:0] addr,
                                input bit last);
            int           len;
            t_scan_report rep;
            len = active_length();
            if (!done) begin
                for (int k = MAX_PATTERN - 1; k > 0; k--) window[k] = window[k-1];
                window[0] = data;
                if (fill < MAX_PATTERN) fill++;
                if (len > 0 && fill >= len && window_hits(len)) begin
                    done      = 1'b1;
                    rep.found = 1'b1;
                    rep.addr  = addr - 64'(len - 1);
                    expected_reports.insert(expected_reports.size(), rep);
                end else if (last) begin
                    rep.found = 1'b0;
                    rep.addr  = '0;
                    expected_reports.insert(expected_reports.size(), rep);
                end
            end
            if (last) clear_region();
        endfunction

        function void check_report(input logic found, input logic [63:0] addr);
            t_scan_report rep;
            if (expected_reports.size() == 0) begin
                $error("unexpected result: found %0b, match_address %h", found, addr);
                errors++;
                return;
            end
            rep = expected_reports.pop_front();
            if (found !== rep.found) begin
                $error("found: expected %0b, got %0b", rep.found, found);
                errors++;
            end
            if (addr !== rep.addr) begin
                $error("match_address: expected %h, got %h", rep.addr, addr);
                errors++;
            end
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic                    i_clk           = 1'b0;
    logic                    i_rst_n         = 1'b0;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    // [7:0] data_byte, [71:8] byte_address
    logic [IN_TDATA_W-1:0]   i_s_axis_tdata  = '0;
    logic                    i_s_axis_tlast  = 1'b0;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    // [63:0] match_address
    logic [OUT_TDATA_W-1:0]  o_m_axis_tdata;
    // [0] found
    logic                    o_m_axis_tuser;
    logic                    psel            = 1'b0;
    logic                    penable         = 1'b0;
    logic                    pwrite          = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr           = '0;
    logic [APB_DATA_W-1:0]   pwdata          = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    scan_scoreboard sb;
    int             cycle_count     = 0;
    int             stall_left      = 0;
    bit             tx_idle_en      = 1'b0;
    bit             closing_stretch = 1'b0;

    wildcard_byte_pattern_scanner DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("wildcard_byte_pattern_scanner_test failed");
            $finish;
        end
    end

    // Result side: stalls come in bursts, and some stretches run without any.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_report(o_m_axis_tuser, o_m_axis_tdata);
            if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else if (!closing_stretch && (cycle_count / 256) % 3 != 0
                         && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 12);
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] data, input logic [63:0] addr,
                             input bit last);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {addr, data};
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_byte(data, addr, last);
        if (tx_idle_en && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 13);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait until every report is in. A region end after a match
    // gives no report, so a settle wait then lets the pipeline empty.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Each write ends with the bus idle before the next setup phase.
    task automatic write_register(input logic [1:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(idx, value);
        @(posedge i_clk);
    endtask

    task automatic load_pattern(input logic [63:0] low, input logic [63:0] high,
                                input logic [15:0] mask, input logic [4:0] len);
        drain();
        write_register(REG_PAT_LOW, low);
        write_register(REG_PAT_HIGH, high);
        write_register(REG_WILD, {48'h0, mask});
        write_register(REG_LEN, {59'h0, len});
    endtask

    // One region of n bytes. A planted copy of the pattern sits at a random
    // offset; a corrupted copy has one non-wildcard position inverted.
    task automatic scan_region(input int n, input bit plant, input bit corrupt);
        logic [7:0]  bytes[];
        logic [63:0] addr;
        int          len;
        int          off;
        int          start;
        int          j;
        len   = sb.active_length();
        bytes = new[n];
        foreach (bytes[i]) begin
            if (len > 0 && $urandom_range(0, 2) == 0)
                bytes[i] = sb.pattern_at($urandom_range(0, len - 1));
            else
                bytes[i] = 8'($urandom);
        end
        if (plant && len > 0 && len <= n) begin
            off = $urandom_range(0, n - len);
            for (int p = 0; p < len; p++) begin
                if (!sb.wild[p]) bytes[off+p] = sb.pattern_at(p);
            end
            if (corrupt) begin
                start = $urandom_range(0, len - 1);
                for (int k = 0; k < len; k++) begin
                    j = (start + k) % len;
                    if (!sb.wild[j]) begin
                        bytes[off+j] = ~bytes[off+j];
                        break;
                    end
                end
            end
        end
        if ($urandom_range(0, 9) == 0)
            addr = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 20));
        else
            addr = {$urandom, $urandom};
        for (int i = 0; i < n; i++) begin
            if (i > 0 && $urandom_range(0, 49) == 0) addr = {$urandom, $urandom};
            send_byte(bytes[i], addr, i == n - 1);
            addr = addr + 64'd1;
        end
    endtask

    initial begin
        int          sent;
        int          n;
        int          kind;
        logic [4:0]  len;
        logic [15:0] mask;
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset pattern: one byte 0x00. Match just after the address wraps, bytes after
        // a match, a one-byte region without a match, a match on the last byte.
        send_byte(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_byte(8'h00, 64'h0, 1'b0);
        send_byte(8'h00, 64'h1, 1'b1);
        send_byte(8'h11, 64'h10, 1'b1);
        send_byte(8'h00, 64'h20, 1'b1);

        // AB ?? CD with the middle position as a wildcard.
        load_pattern(64'h0000_0000_00CD_3FAB, 64'h0, 16'h0002, 5'd3);
        send_byte(8'hAB, 64'h1000, 1'b0);
        send_byte(8'h12, 64'h1001, 1'b0);
        send_byte(8'hCE, 64'h1002, 1'b0);
        send_byte(8'hAB, 64'h1003, 1'b0);
        send_byte(8'h77, 64'h1004, 1'b0);
        send_byte(8'hCD, 64'h1005, 1'b0);
        send_byte(8'hAB, 64'h1006, 1'b0);
        send_byte(8'h00, 64'h1007, 1'b1);
        // Region shorter than the pattern.
        send_byte(8'hAB, 64'h2000, 1'b0);
        send_byte(8'h3F, 64'h2001, 1'b1);
        // Jumping addresses; the start address wraps below zero.
        send_byte(8'hAB, 64'd100, 1'b0);
        send_byte(8'h55, 64'd500, 1'b0);
        send_byte(8'hCD, 64'd1, 1'b1);

        // Length zero never matches.
        load_pattern(64'h0000_0000_00CD_3FAB, 64'h0, 16'h0000, 5'd0);
        send_byte(8'hAB, 64'h0, 1'b0);
        send_byte(8'hCD, 64'h1, 1'b1);

        for (int step = 0; step < STEP_COUNT; step++) begin
            case (step)
                0: load_pattern('1, '1, 16'h0000, 5'd16);
                1: load_pattern('0, '0, 16'hFFFF, 5'd31);
                2: load_pattern({$urandom, $urandom}, {$urandom, $urandom},
                                16'($urandom & $urandom), 5'd17);
                3: load_pattern({$urandom, $urandom}, {$urandom, $urandom},
                                16'h0000, 5'd1);
                4: load_pattern({$urandom, $urandom}, {$urandom, $urandom},
                                16'($urandom), 5'd0);
                default: begin
                    len  = 5'($urandom_range(1, 16));
                    mask = ($urandom_range(0, 2) == 0) ? 16'($urandom)
                                                       : 16'($urandom & $urandom & $urandom);
                    load_pattern({$urandom, $urandom}, {$urandom, $urandom}, mask, len);
                end
            endcase
            if (step == STEP_COUNT - 1) closing_stretch = 1'b1;
            sent = 0;
            while (sent < BYTES_PER_STEP) begin
                kind = $urandom_range(0, 19);
                if (kind < 3)
                    n = $urandom_range(1, 3);
                else if (kind < 5)
                    n = $urandom_range(40, 80);
                else
                    n = $urandom_range(4, 40);
                tx_idle_en = !closing_stretch && $urandom_range(0, 3) != 0;
                kind = $urandom_range(0, 19);
                // Mostly planted copies, some broken ones, some pure noise.
                scan_region(n, kind < 14, kind >= 11 && kind < 14);
                sent += n;
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("wildcard_byte_pattern_scanner_test passed");
        else
            $display("wildcard_byte_pattern_scanner_test failed");
        $finish;
    end

endmodule
